// ===== hw/rtl/pirs_pkg.sv =====
// Package for the positional insert/remove stack: transaction payload types,
// function and status codes, and the controller-to-datapath command structs.
// No dependencies; every other RTL file of the block imports it.
package pirs_pkg;

	// Fixed field widths.
	localparam int FUNC_W = 3;
	localparam int WORD_W = 32;
	localparam int POS_W  = 4;
	localparam int STAT_W = 2;
	localparam int CAP_W  = 5;

	// Capacity reset value.
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Largest number of entries the capacity register can ever allow.
	localparam int CAP_MAX = (1 << CAP_W) - 1;

	// Function codes.
	localparam logic [FUNC_W-1:0] FUNC_PUSH   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_PEEK   = 3'd4;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [STAT_W-1:0] ST_BADPOS    = 2'd3;

	// Request transaction.
	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic signed [WORD_W-1:0] value;
		logic [POS_W-1:0]         position;
	} req_t;

	// Result transaction.
	typedef struct packed {
		logic signed [WORD_W-1:0] data;
		logic [STAT_W-1:0]        status;
		logic [CAP_W-1:0]         occupancy;
		logic                     is_empty;
		logic                     is_full;
	} res_t;

	// Command from the controller to the datapath for one execute cycle.
	typedef struct packed {
		logic                     load;
		logic                     ins;
		logic                     rem;
		logic                     rd;
		logic [CAP_W-1:0]         idx;
		logic signed [WORD_W-1:0] value;
		logic [STAT_W-1:0]        status;
	} cmd_t;

	// Stack status from the datapath to the controller.
	typedef struct packed {
		logic [CAP_W-1:0] count;
		logic             full;
		logic             empty;
	} stat_t;

	// Number of storage cells actually reachable for a given depth.
	function automatic int cell_count(input int depth);
		int n;
		n = (depth < CAP_MAX) ? depth : CAP_MAX;
		return n;
	endfunction

endpackage

// ===== hw/rtl/pirs_ctrl.sv =====
// Controller for the positional insert/remove stack: accepts a request,
// decodes it against the stack status and issues one datapath command.
// Depends on pirs_pkg.
module pirs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  pirs_pkg::req_t  req,
	input  pirs_pkg::stat_t stat,
	output logic            busy,
	output logic            done,
	output pirs_pkg::cmd_t  cmd
);
	import pirs_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t           state_q;
	req_t             req_q;
	logic             done_q;
	logic [CAP_W-1:0] pos_ext;
	logic [CAP_W-1:0] top_idx;
	logic             exec;

	// State, captured request and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == S_EXEC);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request payload needs no reset.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
	end

	assign busy    = (state_q == S_EXEC);
	assign done    = done_q;
	assign exec    = (state_q == S_EXEC);
	assign pos_ext = CAP_W'(req_q.position);
	assign top_idx = stat.count - CAP_W'(1);

	// Decode the operation against the current count and capacity.
	always_comb begin
		cmd        = '0;
		cmd.load   = exec;
		cmd.value  = req_q.value;
		cmd.status = ST_OK;
		case (req_q.func)
			FUNC_PUSH: begin
				if (stat.full) begin
					cmd.status = ST_OVERFLOW;
				end else begin
					cmd.ins = exec;
					cmd.idx = stat.count;
				end
			end
			FUNC_INSERT: begin
				if (stat.full) begin
					cmd.status = ST_OVERFLOW;
				end else if (pos_ext > stat.count) begin
					cmd.status = ST_BADPOS;
				end else begin
					cmd.ins = exec;
					cmd.idx = pos_ext;
				end
			end
			FUNC_POP: begin
				if (stat.empty) begin
					cmd.status = ST_UNDERFLOW;
				end else begin
					cmd.rem = exec;
					cmd.rd  = exec;
					cmd.idx = top_idx;
				end
			end
			FUNC_REMOVE: begin
				if (stat.empty) begin
					cmd.status = ST_UNDERFLOW;
				end else if (pos_ext >= stat.count) begin
					cmd.status = ST_BADPOS;
				end else begin
					cmd.rem = exec;
					cmd.rd  = exec;
					cmd.idx = pos_ext;
				end
			end
			FUNC_PEEK: begin
				if (stat.empty) begin
					cmd.status = ST_UNDERFLOW;
				end else begin
					cmd.rd  = exec;
					cmd.idx = top_idx;
				end
			end
			default: begin
				cmd.status = ST_OK;
			end
		endcase
	end

`ifndef SYNTHESIS
	// An accepted request is executed in the very next cycle.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start) |=> (state_q == S_EXEC))
		else $error("request accepted but not executed");

	// Every execute cycle produces exactly one result strobe.
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> done_q)
		else $error("execute cycle without result strobe");

	// A result is only ever shown while the controller is idle again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while busy");

	// An erroneous operation never changes the stack.
	a_err_noop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.status != ST_OK) |-> (!cmd.ins && !cmd.rem && !cmd.rd))
		else $error("stack changed on an error");
`endif

endmodule

// ===== hw/rtl/pirs_dpath.sv =====
// Datapath for the positional insert/remove stack: storage cells with
// per-cell shift selects, entry count, capacity register and result register.
// Depends on pirs_pkg.
module pirs_dpath #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pirs_pkg::CAP_W-1:0]  cfg_wdata,
	input  pirs_pkg::cmd_t              cmd,
	output pirs_pkg::stat_t             stat,
	output pirs_pkg::res_t              res
);
	import pirs_pkg::*;

	localparam int CELLS = cell_count(DEPTH);
	localparam int IW    = $clog2(CELLS);
	localparam int CNTW  = $clog2(CELLS + 1);

	logic signed [WORD_W-1:0] cells_q [CELLS];
	logic [CNTW-1:0]          cnt_q;
	logic [CNTW-1:0]          cnt_next;
	logic [CAP_W-1:0]         cap_q;
	logic [CAP_W-1:0]         eff_cap;
	logic [IW-1:0]            ix;
	logic signed [WORD_W-1:0] rd_word;
	res_t                     res_q;

	assign ix      = cmd.idx[IW-1:0];
	assign rd_word = cells_q[ix];

	// Capacity is clamped to the range one to the number of cells.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CAP_W'(1);
		end else if (cap_q > CAP_W'(CELLS)) begin
			eff_cap = CAP_W'(CELLS);
		end else begin
			eff_cap = cap_q;
		end
	end

	// Count after this cycle's command.
	always_comb begin
		if (cmd.ins) begin
			cnt_next = cnt_q + CNTW'(1);
		end else if (cmd.rem) begin
			cnt_next = cnt_q - CNTW'(1);
		end else begin
			cnt_next = cnt_q;
		end
	end

	assign stat.count = CAP_W'(cnt_q);
	assign stat.full  = (CAP_W'(cnt_q) >= eff_cap);
	assign stat.empty = (cnt_q == '0);

	// Count and capacity registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cap_q <= CAP_RESET;
		end else begin
			cnt_q <= cnt_next;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	// Each cell loads the new word, its lower or upper neighbour, or holds.
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.ins && (IW'(i) == ix)) begin
				cells_q[i] <= cmd.value;
			end else if (cmd.ins && (IW'(i) > ix)) begin
				if (i > 0) begin
					cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
				end
			end else if (cmd.rem && (IW'(i) >= ix)) begin
				if (i < CELLS - 1) begin
					cells_q[i] <= cells_q[(i < CELLS - 1) ? i + 1 : i];
				end
			end
		end
	end

	// Result register, loaded in the execute cycle.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q.data      <= cmd.rd ? rd_word : '0;
			res_q.status    <= cmd.status;
			res_q.occupancy <= CAP_W'(cnt_next);
			res_q.is_empty  <= (cnt_next == '0);
			res_q.is_full   <= (CAP_W'(cnt_next) >= eff_cap);
		end
	end

	assign res = res_q;

`ifndef SYNTHESIS
	// The count never runs past the number of cells.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CAP_W'(cnt_q) <= CAP_W'(CELLS)))
		else $error("entry count beyond storage");

	// Insert and remove never happen together, nor insert when full.
	a_ins_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> (!cmd.rem && !stat.full))
		else $error("insert while full or together with remove");

	// The reported occupancy is the count the stack now holds.
	a_res_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (res_q.occupancy == CAP_W'(cnt_q)))
		else $error("result occupancy differs from count");
`endif

endmodule

// ===== hw/rtl/positional_insert_remove_stack_core.sv =====
// Top level of the positional insert/remove stack.
// Joins pirs_ctrl and pirs_dpath; depends on pirs_pkg.
//
// A transaction is accepted when start is high and busy is low. The request
// is executed in the following cycle, during which busy is high, and the
// result appears on res with done high for exactly one cycle after that.
// A new transaction can be accepted only once the controller's single
// execute state has passed (the result of one transaction is shown in the
// same cycle as the next one is accepted). The receiver cannot stall; res
// keeps a result until the next request executes; done marks it only once.
// Insert and remove shift all affected entries together. Capacity is
// clamped to one up to the number of storage cells (at most 31 are ever
// reachable), and a capacity lowered below the count drops nothing. No
// clearing pass is needed after reset; entries that were never written are
// never read. Write the capacity only while no transaction is in flight.
module positional_insert_remove_stack_core #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  pirs_pkg::req_t              req,
	output logic                        done,
	output pirs_pkg::res_t              res,
	input  logic                        cfg_we,
	input  logic [pirs_pkg::CAP_W-1:0]  cfg_wdata
);
	import pirs_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Controller: request capture, decode and result strobe.
	pirs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.stat   (stat),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Datapath: storage, count, capacity and result register.
	pirs_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res)
	);

endmodule
